// ===== sv/ortr_pkg.sv =====
package ortr_pkg;

   // table geometry
   localparam int MAX_REGIONS = 64;
   localparam int ID_BITS = $clog2(MAX_REGIONS);
   localparam int CNT_BITS = $clog2(MAX_REGIONS + 1);
   localparam int OFFSET_BITS = 32;
   localparam int ENTRY_BITS = 2 * OFFSET_BITS;

   localparam logic [CNT_BITS-1:0] COUNT_FULL = CNT_BITS'(MAX_REGIONS);
   localparam logic [OFFSET_BITS-1:0] INVALID_OFF = '1;
   localparam logic [OFFSET_BITS-1:0] MAX_OFF = INVALID_OFF - OFFSET_BITS'(1);

   typedef enum logic [0:0] {
      OP_APPEND  = 1'b0,
      OP_RESOLVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LONG  = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_CACHE,
      S_SEARCH,
      S_PROBE,
      S_FINAL
   } state_type;

   // table read address source
   typedef enum logic [1:0] {
      RD_CACHE,
      RD_MID,
      RD_LAST
   } rd_sel_type;

   // kind of result word to emit
   typedef enum logic [1:0] {
      EM_APPEND,
      EM_HIT,
      EM_FINAL,
      EM_MISS
   } emit_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       probe_step;
      logic       emit_en;
      emit_type   emit_kind;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   off_invalid;
      logic   cache_ok;
      logic   cache_hit;
      logic   lo_lt_hi;
      logic   lo_zero;
      logic   final_hit;
   } sts_type;

endpackage

// ===== sv/ortr_ram.sv =====
module ortr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ortr_ctrl.sv =====
module ortr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ortr_pkg::sts_type sts,
   output ortr_pkg::cmd_type cmd,
   output logic             busy
);

   import ortr_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rd_sel = RD_CACHE;
      cmd.emit_kind = EM_MISS;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (sts.op == OP_APPEND) begin
               cmd.emit_en = 1'b1;
               cmd.emit_kind = EM_APPEND;
               state_in = S_IDLE;
            end else if (sts.off_invalid) begin
               cmd.emit_en = 1'b1;
               cmd.emit_kind = EM_MISS;
               state_in = S_IDLE;
            end else if (sts.cache_ok) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = RD_CACHE;
               state_in = S_CACHE;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_CACHE: begin
            if (sts.cache_hit) begin
               cmd.emit_en = 1'b1;
               cmd.emit_kind = EM_HIT;
               state_in = S_IDLE;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            priority if (sts.lo_lt_hi) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = RD_MID;
               state_in = S_PROBE;
            end else if (sts.lo_zero) begin
               cmd.emit_en = 1'b1;
               cmd.emit_kind = EM_MISS;
               state_in = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in = S_FINAL;
            end
         end
         S_PROBE: begin
            cmd.probe_step = 1'b1;
            state_in = S_SEARCH;
         end
         S_FINAL: begin
            cmd.emit_en = 1'b1;
            cmd.emit_kind = sts.final_hit ? EM_FINAL : EM_MISS;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== sv/ortr_dp.sv =====
module ortr_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  ortr_pkg::cmd_type                  cmd,
   output ortr_pkg::sts_type                  sts,
   input  logic                              req_operation,
   input  logic [ortr_pkg::OFFSET_BITS-1:0]  req_region_length,
   input  logic [ortr_pkg::OFFSET_BITS-1:0]  req_global_offset,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [ortr_pkg::ID_BITS-1:0]      rsp_region_id,
   output logic [ortr_pkg::OFFSET_BITS-1:0]  rsp_local_offset
);

   import ortr_pkg::*;

   // request word
   op_type                 op_ff;
   logic [OFFSET_BITS-1:0] len_ff;
   logic [OFFSET_BITS-1:0] off_ff;

   // table state
   logic [CNT_BITS-1:0]    count_ff;
   logic [OFFSET_BITS-1:0] next_base_ff;
   logic                   nb_invalid_ff;
   logic [ID_BITS-1:0]     last_hit_id_ff;
   logic                   last_hit_valid_ff;

   // search window
   logic [CNT_BITS-1:0]    lo_ff;
   logic [CNT_BITS-1:0]    hi_ff;
   logic [ID_BITS-1:0]     rd_addr_ff;

   // result word
   logic                   rsp_strobe_ff;
   status_type             rsp_status_ff;
   logic [ID_BITS-1:0]     rsp_id_ff;
   logic [OFFSET_BITS-1:0] rsp_local_ff;

   logic [CNT_BITS-1:0]    mid;
   logic [ID_BITS-1:0]     rd_addr;
   logic [ENTRY_BITS-1:0]  rd_data;
   logic [OFFSET_BITS-1:0] rd_base;
   logic [OFFSET_BITS-1:0] rd_end;
   logic [OFFSET_BITS-1:0] local_diff;
   logic [OFFSET_BITS-1:0] app_end;
   logic                   too_long;
   logic                   full;
   logic                   wr_en;

   // split the table entry
   assign rd_base = rd_data[OFFSET_BITS-1:0];
   assign rd_end = rd_data[ENTRY_BITS-1:OFFSET_BITS];
   assign local_diff = off_ff - rd_base;

   // append checks
   assign too_long = nb_invalid_ff || (len_ff > (MAX_OFF - next_base_ff));
   assign full = (count_ff == COUNT_FULL);
   assign app_end = next_base_ff + len_ff;
   assign wr_en = cmd.emit_en && (cmd.emit_kind == EM_APPEND) && !too_long && !full;

   // probe address and read address select
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   always_comb begin
      unique case (cmd.rd_sel)
         RD_CACHE: rd_addr = last_hit_id_ff;
         RD_MID:   rd_addr = mid[ID_BITS-1:0];
         RD_LAST:  rd_addr = ID_BITS'(lo_ff - CNT_BITS'(1));
         default:  rd_addr = last_hit_id_ff;
      endcase
   end

   ortr_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(MAX_REGIONS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[ID_BITS-1:0]),
      .wr_data({app_end, next_base_ff}),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // status to the controller
   always_comb begin
      sts.op = op_ff;
      sts.off_invalid = (off_ff == INVALID_OFF);
      sts.cache_ok = last_hit_valid_ff && ({1'b0, last_hit_id_ff} < count_ff);
      sts.cache_hit = (off_ff >= rd_base) && (off_ff <= rd_end);
      sts.lo_lt_hi = (lo_ff < hi_ff);
      sts.lo_zero = (lo_ff == '0);
      sts.final_hit = (off_ff <= rd_end);
   end

   // latch request, step the search window
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op_type'(req_operation);
         len_ff <= req_region_length;
         off_ff <= req_global_offset;
         lo_ff <= '0;
         hi_ff <= count_ff;
      end else if (cmd.probe_step) begin
         if (off_ff < rd_base) begin
            hi_ff <= mid;
         end else begin
            lo_ff <= mid + CNT_BITS'(1);
         end
      end
      if (cmd.rd_en) begin
         rd_addr_ff <= rd_addr;
      end
   end

   // table bookkeeping and last-hit cache
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         next_base_ff <= '0;
         nb_invalid_ff <= 1'b0;
         last_hit_id_ff <= '0;
         last_hit_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            count_ff <= count_ff + CNT_BITS'(1);
            if (app_end < MAX_OFF) begin
               next_base_ff <= app_end + OFFSET_BITS'(1);
            end else begin
               next_base_ff <= '0;
               nb_invalid_ff <= 1'b1;
            end
         end
         if (cmd.emit_en && (cmd.emit_kind == EM_FINAL)) begin
            last_hit_id_ff <= rd_addr_ff;
            last_hit_valid_ff <= 1'b1;
         end
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit_en;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.emit_en) begin
         rsp_status_ff <= ST_NOT_FOUND;
         rsp_id_ff <= '0;
         rsp_local_ff <= '0;
         unique case (cmd.emit_kind)
            EM_APPEND: begin
               priority if (too_long) begin
                  rsp_status_ff <= ST_TOO_LONG;
               end else if (full) begin
                  rsp_status_ff <= ST_FULL;
               end else begin
                  rsp_status_ff <= ST_OK;
                  rsp_id_ff <= count_ff[ID_BITS-1:0];
                  rsp_local_ff <= next_base_ff;
               end
            end
            EM_HIT, EM_FINAL: begin
               rsp_status_ff <= ST_OK;
               rsp_id_ff <= rd_addr_ff;
               rsp_local_ff <= local_diff;
            end
            EM_MISS: begin
               rsp_status_ff <= ST_NOT_FOUND;
            end
            default: begin
               rsp_status_ff <= ST_NOT_FOUND;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_region_id = rsp_id_ff;
   assign rsp_local_offset = rsp_local_ff;

   // a result word never follows another in the next cycle
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobes in back-to-back cycles");

   // the table never grows past its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("region count past table depth");

   // a table write only lands below the depth
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < COUNT_FULL))
      else $error("table write with table full");

   // a cached id always names a filled entry
   a_cache_filled: assert property (@(posedge clock) disable iff (reset)
      last_hit_valid_ff |-> ({1'b0, last_hit_id_ff} < count_ff))
      else $error("last hit points past filled entries");

endmodule

// ===== sv/offset_range_table_resolver.sv =====
// Channel   Ports                                         Handshake
// request   req_operation, req_region_length,             start && !busy
//           req_global_offset
// result    rsp_status, rsp_region_id, rsp_local_offset   rsp_strobe, one cycle
//
// Append: accept latches the request, S_DISPATCH checks and writes, and the
// result strobe is registered from that. Resolve: an invalid offset misses from
// S_DISPATCH, a last-hit match answers from S_CACHE, else a binary search runs;
// each probe reads the region table in S_SEARCH and compares in S_PROBE.
// busy stays high from accept until the cycle the result strobe shows; a new
// word may be taken in that strobe cycle.
// Reset clears the region count, next base and last-hit cache; the table needs
// no clearing. The receiver cannot stall; each result shows for one cycle only.
module offset_range_table_resolver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_operation,
   input  logic [ortr_pkg::OFFSET_BITS-1:0]  req_region_length,
   input  logic [ortr_pkg::OFFSET_BITS-1:0]  req_global_offset,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [ortr_pkg::ID_BITS-1:0]      rsp_region_id,
   output logic [ortr_pkg::OFFSET_BITS-1:0]  rsp_local_offset
);

   import ortr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ortr_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .sts  (sts),
      .cmd  (cmd),
      .busy (busy)
   );

   ortr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_region_length(req_region_length),
      .req_global_offset(req_global_offset),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_region_id    (rsp_region_id),
      .rsp_local_offset (rsp_local_offset)
   );

endmodule
